>>> sv/frg_pkg.sv
// ----------------------------------------------------------------------------
// Step rate generator package
// Shared widths, operation and prescaler codes, result types and the
// prescaler tables of the step rate generator.
// ----------------------------------------------------------------------------
`default_nettype none

package frg_pkg;

    localparam int CLOCK_HZ    = 16000000;
    localparam int PULSE_TICKS = 64;
    localparam int MAX_RATE_HZ = 2000;

    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int RATE_W  = 11;
    localparam int SEL_W   = 3;
    localparam int CMP_W   = 16;
    localparam int PCNT_W  = 10;
    localparam int PULSE_W = 7;
    localparam int PROD_W  = 63;
    localparam int FLOW_W  = DATA_W - 1;
    localparam int SPM_W   = 17;

    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int DIV_W  = (CLK_W > 24) ? CLK_W : 24;
    localparam int DIVR_W = RATE_W;

    localparam int FLOW_SCALE  = 100;
    localparam int SEC_PER_MIN = 60;
    localparam int ROUND_UP    = SEC_PER_MIN - 1;
    localparam int FLOW_CLAMP  = (SEC_PER_MIN * MAX_RATE_HZ + 1) * FLOW_SCALE;
    localparam int CMP_SPAN    = 65536;
    localparam int CMP_MAX     = 65535;
    localparam int MATCH_RESET = 2000;

    // Reciprocals that divide any 32-bit operand exactly by 100 and by 60 when the
    // product is taken from bit RECIP_SHIFT upwards.
    localparam int                RECIP_SHIFT = 37;
    localparam logic [DATA_W-1:0] RECIP_100   = 32'h51EB_851F;
    localparam logic [DATA_W-1:0] RECIP_60    = 32'h8888_8889;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_RUN_FLOW = 3'd1,
        OP_RUN_RATE = 3'd2,
        OP_STOP     = 3'd3,
        OP_SET_EN   = 3'd4
    } op_t;

    localparam logic [SEL_W-1:0] SEL_OFF   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_P1    = 3'd1;
    localparam logic [SEL_W-1:0] SEL_P8    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_P64   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_P256  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_P1024 = 3'd5;

    typedef struct packed {
        logic                stop;
        logic [RATE_W-1:0]   hz;
        logic [SEL_W-1:0]    sel;
        logic [CMP_W-1:0]    ocr;
    } load_t;

    typedef struct packed {
        logic start;
        logic ack;
    } calc_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } calc_stat_t;

    typedef struct packed {
        logic                step_out;
        logic                driver_disable;
        logic [RATE_W-1:0]   rate_hz;
        logic [SEL_W-1:0]    prescale_select;
        logic [CMP_W-1:0]    compare_value;
    } result_t;

    function automatic logic [DIV_W-1:0] presc_dividend(input logic [SEL_W-1:0] sel);
        logic [DIV_W-1:0] val;
        val = '0;
        unique case (sel)
            SEL_P1:    val = DIV_W'(CLOCK_HZ);
            SEL_P8:    val = DIV_W'(CLOCK_HZ / 8);
            SEL_P64:   val = DIV_W'(CLOCK_HZ / 64);
            SEL_P256:  val = DIV_W'(CLOCK_HZ / 256);
            SEL_P1024: val = DIV_W'(CLOCK_HZ / 1024);
            default:   val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [PCNT_W-1:0] presc_last(input logic [SEL_W-1:0] sel);
        logic [PCNT_W-1:0] val;
        val = '0;
        unique case (sel)
            SEL_P1:    val = PCNT_W'(0);
            SEL_P8:    val = PCNT_W'(7);
            SEL_P64:   val = PCNT_W'(63);
            SEL_P256:  val = PCNT_W'(255);
            SEL_P1024: val = PCNT_W'(1023);
            default:   val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> sv/frg_if.sv
// ----------------------------------------------------------------------------
// Step rate generator channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface frg_cmd_if;
    import frg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] flow_hundredths;
    logic [DATA_W-1:0]        steps_per_sec;
    logic                     enable_flag;

    modport source (output valid, opcode, flow_hundredths, steps_per_sec, enable_flag,
                    input ready);
    modport sink   (input valid, opcode, flow_hundredths, steps_per_sec, enable_flag,
                    output ready);
endinterface

interface frg_res_if;
    import frg_pkg::*;

    logic                valid;
    logic                ready;
    logic                step_out;
    logic                driver_disable;
    logic [RATE_W-1:0]   rate_hz;
    logic [SEL_W-1:0]    prescale_select;
    logic [CMP_W-1:0]    compare_value;

    modport source (output valid, step_out, driver_disable, rate_hz, prescale_select,
                    compare_value, input ready);
    modport sink   (input valid, step_out, driver_disable, rate_hz, prescale_select,
                    compare_value, output ready);
endinterface

`default_nettype wire

>>> sv/flow_to_step_rate_generator.sv
// ----------------------------------------------------------------------------
// Flow to step rate generator
// Stepper pump rate generator: turns flow or rate commands into a prescaled
// compare timer setting and produces step pulses on tick transactions.
//
// Channel   Direction  Handshake     Contents
// cmd       in         valid/ready   opcode, flow, rate, enable flag
// status    out        valid/ready   step level, driver disable, rate, timer set
// cfg       in         write enable  pump gain register
//
// Tick, stop and enable transactions give their status straight from the input register,
// once status is free. A run by rate tries one prescaler after another, from the
// smallest, on the shared restoring divider; a run by flow first forms the product and
// divides it by 100 and by 60 on the shared multiplier, skipping both when it clamps.
// Reset is asynchronous and active low; there is no clearing pass.
// One command is held in an input register while a result waits on status.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_to_step_rate_generator
    import frg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    frg_cmd_if.sink                cmd,
    frg_res_if.source              status,
    input  wire logic              cfg_wr_en,
    input  wire logic [DATA_W-1:0] cfg_wr_data
);

    logic                     pend_valid_reg;
    logic                     pend_valid_next;
    logic [OP_W-1:0]          pend_op_reg;
    logic signed [DATA_W-1:0] pend_flow_reg;
    logic [DATA_W-1:0]        pend_sps_reg;
    logic                     pend_en_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DATA_W-1:0]        pump_gain_reg;
    logic                     take;
    logic                     is_run;
    logic                     out_free;
    logic                     finish;
    calc_ctl_t                calc_ctl;
    calc_stat_t               calc_stat;
    load_t                    load;
    result_t                  result;

    always_comb
    begin
        is_run          = (pend_op_reg == OP_RUN_FLOW) || (pend_op_reg == OP_RUN_RATE);
        out_free        = !out_valid_reg || status.ready;
        finish          = pend_valid_reg && out_free && (!is_run || calc_stat.done);
        calc_ctl.start  = pend_valid_reg && is_run && calc_stat.idle;
        calc_ctl.ack    = finish;
        take            = cmd.valid && cmd.ready;
        pend_valid_next = take ? 1'b1 : (finish ? 1'b0 : pend_valid_reg);
        out_valid_next  = finish ? 1'b1 : (status.ready ? 1'b0 : out_valid_reg);
    end

    assign cmd.ready = !pend_valid_reg || finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pump_gain_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                pump_gain_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_op_reg   <= cmd.opcode;
            pend_flow_reg <= cmd.flow_hundredths;
            pend_sps_reg  <= cmd.steps_per_sec;
            pend_en_reg   <= cmd.enable_flag;
        end
    end

    frg_rate_calc u_rate_calc (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (calc_ctl),
        .opcode          (pend_op_reg),
        .flow_hundredths (pend_flow_reg),
        .steps_per_sec   (pend_sps_reg),
        .pump_gain       (pump_gain_reg),
        .stat            (calc_stat),
        .load            (load)
    );

    frg_timer u_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .apply       (finish),
        .opcode      (pend_op_reg),
        .enable_flag (pend_en_reg),
        .load        (load),
        .result      (result)
    );

    assign status.valid           = out_valid_reg;
    assign status.step_out        = result.step_out;
    assign status.driver_disable  = result.driver_disable;
    assign status.rate_hz         = result.rate_hz;
    assign status.prescale_select = result.prescale_select;
    assign status.compare_value   = result.compare_value;

endmodule

`default_nettype wire

>>> sv/frg_divider.sv
// ----------------------------------------------------------------------------
// Step rate generator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frg_divider
    import frg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] rem_next;
    logic [DIV_W-1:0]  quot_reg;
    logic [DIV_W-1:0]  quot_next;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVR_W-1:0] dvs_next;
    logic [DIVR_W:0]   trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (go && !busy_reg)
        begin
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? DIVR_W'(trial - {1'b0, dvs_reg}) : trial[DIVR_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !busy_reg)
        else $error("Divider started while a division was still running.");

endmodule

`default_nettype wire

>>> sv/frg_rate_calc.sv
// ----------------------------------------------------------------------------
// Step rate generator rate calculation
// Sequencer that turns a run command into a step rate, a prescaler and a
// compare value, or into a stop, using the shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module frg_rate_calc
    import frg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire calc_ctl_t                ctl,
    input  wire logic [OP_W-1:0]          opcode,
    input  wire logic signed [DATA_W-1:0] flow_hundredths,
    input  wire logic [DATA_W-1:0]        steps_per_sec,
    input  wire logic [DATA_W-1:0]        pump_gain,
    output calc_stat_t                    stat,
    output load_t                         load
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_CHECK,
        C_DIV,
        C_DONE
    } calc_state_t;

    typedef enum logic [1:0] {
        PH_PRODUCT,
        PH_DIV100,
        PH_DIV60,
        PH_SEARCH
    } phase_t;

    calc_state_t        state_reg;
    calc_state_t        state_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [DATA_W-2:0]  flow_reg;
    logic [DATA_W-2:0]  flow_next;
    logic [DATA_W-1:0]  gain_reg;
    logic [DATA_W-1:0]  gain_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [RATE_W-1:0]  hz_reg;
    logic [RATE_W-1:0]  hz_next;
    logic [SEL_W-1:0]   idx_reg;
    logic [SEL_W-1:0]   idx_next;
    load_t              res_reg;
    load_t              res_next;
    logic               go_reg;
    logic               go_next;
    logic [DIV_W-1:0]   div_a_reg;
    logic [DIV_W-1:0]   div_a_next;
    logic [DIVR_W-1:0]  div_b_reg;
    logic [DIVR_W-1:0]  div_b_next;
    logic               div_busy;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic [RATE_W-1:0]  rate_clamped;
    logic               q_fits;
    logic [SPM_W-1:0]   spm;
    logic [RATE_W-1:0]  scaled_hz;

    frg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        rate_clamped = (steps_per_sec > DATA_W'(MAX_RATE_HZ)) ? RATE_W'(MAX_RATE_HZ)
                                                              : steps_per_sec[RATE_W-1:0];
        q_fits     = (div_q != '0) && (div_q <= DIV_W'(CMP_SPAN));
        spm        = prod_reg[RECIP_SHIFT +: SPM_W];
        scaled_hz  = prod_reg[RECIP_SHIFT +: RATE_W];
        state_next = state_reg;
        phase_next = phase_reg;
        flow_next  = flow_reg;
        gain_next  = gain_reg;
        prod_next  = prod_reg;
        hz_next    = hz_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        go_next    = 1'b0;
        div_a_next = div_a_reg;
        div_b_next = div_b_reg;

        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    res_next = '0;
                    if (opcode == OP_RUN_RATE)
                    begin
                        if (steps_per_sec == '0)
                        begin
                            res_next.stop = 1'b1;
                            state_next    = C_DONE;
                        end
                        else
                        begin
                            hz_next    = rate_clamped;
                            idx_next   = SEL_P1;
                            div_a_next = presc_dividend(SEL_P1);
                            div_b_next = DIVR_W'(rate_clamped);
                            phase_next = PH_SEARCH;
                            go_next    = 1'b1;
                            state_next = C_DIV;
                        end
                    end
                    else if (flow_hundredths[DATA_W-1] || flow_hundredths == '0
                             || pump_gain == '0)
                    begin
                        res_next.stop = 1'b1;
                        state_next    = C_DONE;
                    end
                    else
                    begin
                        flow_next  = flow_hundredths[DATA_W-2:0];
                        gain_next  = pump_gain;
                        phase_next = PH_PRODUCT;
                        state_next = C_MUL;
                    end
                end
            end
            C_MUL:
            begin
                prod_next  = PROD_W'(flow_reg) * PROD_W'(gain_reg);
                state_next = C_CHECK;
            end
            C_CHECK:
            begin
                unique case (phase_reg)
                    PH_PRODUCT:
                    begin
                        if (prod_reg >= PROD_W'(FLOW_CLAMP))
                        begin
                            hz_next    = RATE_W'(MAX_RATE_HZ);
                            idx_next   = SEL_P1;
                            div_a_next = presc_dividend(SEL_P1);
                            div_b_next = DIVR_W'(MAX_RATE_HZ);
                            phase_next = PH_SEARCH;
                            go_next    = 1'b1;
                            state_next = C_DIV;
                        end
                        else
                        begin
                            flow_next  = FLOW_W'(prod_reg[DIV_W-1:0]);
                            gain_next  = RECIP_100;
                            phase_next = PH_DIV100;
                            state_next = C_MUL;
                        end
                    end
                    PH_DIV100:
                    begin
                        if (spm == '0)
                        begin
                            res_next.stop = 1'b1;
                            state_next    = C_DONE;
                        end
                        else
                        begin
                            flow_next  = FLOW_W'(spm) + FLOW_W'(ROUND_UP);
                            gain_next  = RECIP_60;
                            phase_next = PH_DIV60;
                            state_next = C_MUL;
                        end
                    end
                    PH_DIV60:
                    begin
                        hz_next    = scaled_hz;
                        idx_next   = SEL_P1;
                        div_a_next = presc_dividend(SEL_P1);
                        div_b_next = DIVR_W'(scaled_hz);
                        phase_next = PH_SEARCH;
                        go_next    = 1'b1;
                        state_next = C_DIV;
                    end
                    default:
                    begin
                        state_next = C_IDLE;
                    end
                endcase
            end
            C_DIV:
            begin
                if (div_done)
                begin
                    if (q_fits)
                    begin
                        res_next.hz  = hz_reg;
                        res_next.sel = idx_reg;
                        res_next.ocr = CMP_W'(div_q - DIV_W'(1));
                        state_next   = C_DONE;
                    end
                    else if (idx_reg == SEL_P1024)
                    begin
                        res_next.hz  = hz_reg;
                        res_next.sel = SEL_P1024;
                        res_next.ocr = CMP_W'(CMP_MAX);
                        state_next   = C_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SEL_W'(1);
                        div_a_next = presc_dividend(idx_reg + SEL_W'(1));
                        go_next    = 1'b1;
                    end
                end
            end
            C_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            phase_reg <= PH_DIV100;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            go_reg    <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg  <= flow_next;
        gain_reg  <= gain_next;
        prod_reg  <= prod_next;
        hz_reg    <= hz_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        div_a_reg <= div_a_next;
        div_b_reg <= div_b_next;
    end

    assign stat.idle = (state_reg == C_IDLE);
    assign stat.done = (state_reg == C_DONE);
    assign load      = res_reg;

    a_load_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DONE && !res_reg.stop)
            |-> (res_reg.sel != SEL_OFF && res_reg.hz != '0 && !div_busy))
        else $error("Rate result offered without a valid prescaler and rate.");

endmodule

`default_nettype wire

>>> sv/frg_timer.sv
// ----------------------------------------------------------------------------
// Step rate generator timer
// Prescaled compare counter, step pulse and enable state, updated once for
// each completed command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module frg_timer
    import frg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            apply,
    input  wire logic [OP_W-1:0] opcode,
    input  wire logic            enable_flag,
    input  wire load_t           load,
    output result_t              result
);

    logic                stepping_reg;
    logic                stepping_next;
    logic                drv_off_reg;
    logic                drv_off_next;
    logic [SEL_W-1:0]    sel_reg;
    logic [SEL_W-1:0]    sel_next;
    logic [CMP_W-1:0]    match_reg;
    logic [CMP_W-1:0]    match_next;
    logic [PCNT_W-1:0]   pcnt_reg;
    logic [PCNT_W-1:0]   pcnt_next;
    logic [CMP_W-1:0]    period_reg;
    logic [CMP_W-1:0]    period_next;
    logic [PULSE_W-1:0]  pulse_reg;
    logic [PULSE_W-1:0]  pulse_next;
    logic [RATE_W-1:0]   rate_reg;
    logic [RATE_W-1:0]   rate_next;

    always_comb
    begin
        stepping_next = stepping_reg;
        drv_off_next  = drv_off_reg;
        sel_next      = sel_reg;
        match_next    = match_reg;
        pcnt_next     = pcnt_reg;
        period_next   = period_reg;
        pulse_next    = pulse_reg;
        rate_next     = rate_reg;
        if (apply)
        begin
            unique case (opcode)
                OP_TICK:
                begin
                    if (pulse_reg != '0)
                    begin
                        pulse_next = pulse_reg - PULSE_W'(1);
                    end
                    if (sel_reg != SEL_OFF)
                    begin
                        if (pcnt_reg >= presc_last(sel_reg))
                        begin
                            pcnt_next = '0;
                            if (period_reg == match_reg)
                            begin
                                period_next = '0;
                                if (stepping_reg)
                                begin
                                    pulse_next = PULSE_W'(PULSE_TICKS);
                                end
                            end
                            else
                            begin
                                period_next = period_reg + CMP_W'(1);
                            end
                        end
                        else
                        begin
                            pcnt_next = pcnt_reg + PCNT_W'(1);
                        end
                    end
                end
                OP_RUN_FLOW, OP_RUN_RATE:
                begin
                    if (load.stop)
                    begin
                        stepping_next = 1'b0;
                        drv_off_next  = 1'b1;
                    end
                    else
                    begin
                        rate_next     = load.hz;
                        sel_next      = load.sel;
                        match_next    = load.ocr;
                        pcnt_next     = '0;
                        period_next   = '0;
                        stepping_next = 1'b1;
                        drv_off_next  = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    stepping_next = 1'b0;
                    drv_off_next  = 1'b1;
                end
                OP_SET_EN:
                begin
                    stepping_next = enable_flag;
                    drv_off_next  = !enable_flag;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stepping_reg <= 1'b0;
            drv_off_reg  <= 1'b1;
            sel_reg      <= SEL_OFF;
            match_reg    <= CMP_W'(MATCH_RESET);
            pcnt_reg     <= '0;
            period_reg   <= '0;
            pulse_reg    <= '0;
            rate_reg     <= '0;
        end
        else
        begin
            stepping_reg <= stepping_next;
            drv_off_reg  <= drv_off_next;
            sel_reg      <= sel_next;
            match_reg    <= match_next;
            pcnt_reg     <= pcnt_next;
            period_reg   <= period_next;
            pulse_reg    <= pulse_next;
            rate_reg     <= rate_next;
        end
    end

    assign result.step_out        = (pulse_reg != '0);
    assign result.driver_disable  = drv_off_reg;
    assign result.rate_hz         = rate_reg;
    assign result.prescale_select = sel_reg;
    assign result.compare_value   = match_reg;

    a_period_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg <= match_reg)
        else $error("Period counter has passed the compare value.");

    a_pulse_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pulse_reg != '0) |-> $past(stepping_reg))
        else $error("Step pulse started while stepping was disabled.");

endmodule

`default_nettype wire

>>> verif/frg_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step rate generator status checker
// Watches the command and status channels and the gain register port, keeps
// its own copy of the rate generator state and checks every status
// transaction, field by field, against the oldest predicted status.
// ----------------------------------------------------------------------------

module frg_status_checker
    import frg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    frg_cmd_if                     cmd_mon,
    frg_res_if                     status_mon,
    input  wire logic              cfg_wr_en,
    input  wire logic [DATA_W-1:0] cfg_wr_data,
    output int unsigned            mismatches,
    output int unsigned            pending
);

    logic [DATA_W-1:0] gain_reg;
    logic              step_enabled;
    logic              driver_off;
    logic [SEL_W-1:0]  timer_sel;
    logic [CMP_W-1:0]  timer_match;
    int unsigned       presc_count;
    logic [CMP_W-1:0]  period_count;
    int unsigned       pulse_left;
    logic [RATE_W-1:0] rate_loaded;

    result_t status_expected[$];
    result_t oldest;

    function automatic int unsigned prescale_ratio(input logic [SEL_W-1:0] sel);
        case (sel)
            SEL_P1:    return 1;
            SEL_P8:    return 8;
            SEL_P64:   return 64;
            SEL_P256:  return 256;
            SEL_P1024: return 1024;
            default:   return 0;
        endcase
    endfunction

    function automatic result_t current_status();
        result_t st;
        st.step_out        = (pulse_left != 0);
        st.driver_disable  = driver_off;
        st.rate_hz         = rate_loaded;
        st.prescale_select = timer_sel;
        st.compare_value   = timer_match;
        return st;
    endfunction

    task automatic halt_stepping();
        step_enabled = 1'b0;
        driver_off   = 1'b1;
    endtask

    task automatic load_step_rate(input logic [63:0] hz);
        logic [63:0]      q;
        logic [SEL_W-1:0] sel_n;
        logic [CMP_W-1:0] ocr_n;
        logic             found;
        int               s;
        if (hz < 64'd1)
        begin
            hz = 64'd1;
        end
        if (hz > 64'(MAX_RATE_HZ))
        begin
            hz = 64'(MAX_RATE_HZ);
        end
        sel_n = SEL_P1024;
        ocr_n = CMP_W'(CMP_MAX);
        found = 1'b0;
        for (s = SEL_P1; s <= SEL_P1024; s++)
        begin
            if (!found)
            begin
                q = 64'(CLOCK_HZ / prescale_ratio(SEL_W'(s))) / hz;
                if (q >= 64'd1 && q - 64'd1 <= 64'(CMP_MAX))
                begin
                    sel_n = SEL_W'(s);
                    ocr_n = CMP_W'(q - 64'd1);
                    found = 1'b1;
                end
            end
        end
        rate_loaded  = RATE_W'(hz);
        timer_sel    = sel_n;
        timer_match  = ocr_n;
        presc_count  = 0;
        period_count = '0;
        step_enabled = 1'b1;
        driver_off   = 1'b0;
    endtask

    task automatic advance_timer();
        if (pulse_left != 0)
        begin
            pulse_left--;
        end
        if (timer_sel != SEL_OFF && timer_sel <= SEL_P1024)
        begin
            if (presc_count + 1 >= prescale_ratio(timer_sel))
            begin
                presc_count = 0;
                if (period_count == timer_match)
                begin
                    period_count = '0;
                    if (step_enabled)
                    begin
                        pulse_left = PULSE_TICKS;
                    end
                end
                else
                begin
                    period_count = period_count + 1'b1;
                end
            end
            else
            begin
                presc_count++;
            end
        end
    endtask

    task automatic apply_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] flow,
                                 input logic [DATA_W-1:0] sps, input logic en);
        logic [63:0] spm;
        case (op)
            OP_TICK:
            begin
                advance_timer();
            end
            OP_RUN_FLOW:
            begin
                if (flow[DATA_W-1] || flow == '0 || gain_reg == '0)
                begin
                    halt_stepping();
                end
                else
                begin
                    spm = (64'(flow) * 64'(gain_reg)) / 64'(FLOW_SCALE);
                    if (spm == 64'd0)
                    begin
                        halt_stepping();
                    end
                    else
                    begin
                        load_step_rate((spm + 64'(ROUND_UP)) / 64'(SEC_PER_MIN));
                    end
                end
            end
            OP_RUN_RATE:
            begin
                if (sps == '0)
                begin
                    halt_stepping();
                end
                else
                begin
                    load_step_rate(64'(sps));
                end
            end
            OP_STOP:
            begin
                halt_stepping();
            end
            OP_SET_EN:
            begin
                step_enabled = en;
                driver_off   = !en;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     = '0;
            step_enabled = 1'b0;
            driver_off   = 1'b1;
            timer_sel    = SEL_OFF;
            timer_match  = CMP_W'(MATCH_RESET);
            presc_count  = 0;
            period_count = '0;
            pulse_left   = 0;
            rate_loaded  = '0;
            mismatches   = 0;
            status_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gain_reg = cfg_wr_data;
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                apply_command(cmd_mon.opcode, cmd_mon.flow_hundredths,
                              cmd_mon.steps_per_sec, cmd_mon.enable_flag);
                status_expected.push_back(current_status());
            end
            if (status_mon.valid && status_mon.ready)
            begin
                if (status_expected.size() == 0)
                begin
                    $error("status transaction arrived with no expected status");
                    mismatches++;
                end
                else
                begin
                    oldest = status_expected.pop_front();
                    check_field("step_out", oldest.step_out, status_mon.step_out);
                    check_field("driver_disable", oldest.driver_disable,
                                status_mon.driver_disable);
                    check_field("rate_hz", oldest.rate_hz, status_mon.rate_hz);
                    check_field("prescale_select", oldest.prescale_select,
                                status_mon.prescale_select);
                    check_field("compare_value", oldest.compare_value,
                                status_mon.compare_value);
                end
            end
            pending <= status_expected.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Step rate generator testbench
// Drives directed and random command transactions into the rate generator,
// changes the pump gain between phases, stalls both channels at random and
// leaves the checking to the status checker.
// ----------------------------------------------------------------------------

module tb;
    import frg_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [DATA_W-1:0] cfg_wr_data;
    logic              no_idle;
    int unsigned       idle_cycles;
    int unsigned       mismatches;
    int unsigned       pending;

    frg_cmd_if cmd_ch ();
    frg_res_if status_ch ();

    flow_to_step_rate_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .status      (status_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frg_status_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_mon     (cmd_ch),
        .status_mon  (status_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_cmd(input op_t op, input logic [DATA_W-1:0] flow,
                            input logic [DATA_W-1:0] sps, input logic en);
        int gap;
        cmd_ch.valid           <= 1'b1;
        cmd_ch.opcode          <= op;
        cmd_ch.flow_hundredths <= flow;
        cmd_ch.steps_per_sec   <= sps;
        cmd_ch.enable_flag     <= en;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_gain(input logic [DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int          gap;
        status_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            status_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                status_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int unsigned       pick;
        logic [DATA_W-1:0] flow_v;
        logic [DATA_W-1:0] rate_v;
        logic [DATA_W-1:0] gain_v;
        op_t               op_v;
        int                phase;
        rst_n                  <= 1'b0;
        no_idle                <= 1'b0;
        idle_cycles            <= 0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= '0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.opcode          <= OP_TICK;
        cmd_ch.flow_hundredths <= '0;
        cmd_ch.steps_per_sec   <= '0;
        cmd_ch.enable_flag     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gain still at its reset value of zero.
        send_cmd(OP_TICK, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'd100, 32'd0, 1'b0);
        send_cmd(OP_SET_EN, 32'd0, 32'd0, 1'b1);
        send_cmd(OP_TICK, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_SET_EN, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_RUN_RATE, 32'd0, 32'd1, 1'b0);
        send_cmd(OP_TICK, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_RUN_RATE, 32'd0, 32'd2000, 1'b0);
        send_cmd(OP_RUN_RATE, 32'd0, 32'hFFFF_FFFF, 1'b0);
        send_cmd(OP_RUN_RATE, 32'd0, 32'd2001, 1'b0);
        send_cmd(OP_RUN_RATE, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_for_results();

        write_gain(32'hFFFF_FFFF);
        send_cmd(OP_RUN_FLOW, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'h8000_0000, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'd0, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'd1, 32'd0, 1'b0);
        wait_for_results();

        write_gain(32'd1);
        send_cmd(OP_RUN_FLOW, 32'd1, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'd100, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'd6100, 32'd0, 1'b0);
        send_cmd(OP_RUN_FLOW, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_cmd(OP_TICK, 32'd0, 32'd0, 1'b0);

        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            case (phase % 5)
                0:       gain_v = 32'd0;
                1:       gain_v = 32'd1;
                2:       gain_v = 32'hFFFF_FFFF;
                3:       gain_v = $urandom_range(1, 600);
                default: gain_v = $urandom();
            endcase
            write_gain(gain_v);
            no_idle <= (phase == 3);
            repeat (125)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    op_v = OP_TICK;
                end
                else if (pick < 67)
                begin
                    op_v = OP_RUN_FLOW;
                end
                else if (pick < 79)
                begin
                    op_v = OP_RUN_RATE;
                end
                else if (pick < 86)
                begin
                    op_v = OP_STOP;
                end
                else
                begin
                    op_v = OP_SET_EN;
                end
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    flow_v = $urandom();
                end
                else if (pick == 2)
                begin
                    case ($urandom_range(0, 2))
                        0:       flow_v = 32'd0;
                        1:       flow_v = 32'h8000_0000;
                        default: flow_v = 32'h7FFF_FFFF;
                    endcase
                end
                else
                begin
                    flow_v = $urandom_range(1, 200000);
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    rate_v = 32'd0;
                end
                else if (pick == 1)
                begin
                    rate_v = $urandom();
                end
                else if (pick == 2)
                begin
                    rate_v = $urandom_range(1999, 2001);
                end
                else
                begin
                    rate_v = $urandom_range(1, 2500);
                end
                send_cmd(op_v, flow_v, rate_v, 1'($urandom_range(0, 1)));
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> flow_to_step_rate_generator.f
sv/frg_pkg.sv
sv/frg_if.sv
sv/frg_divider.sv
sv/frg_rate_calc.sv
sv/frg_timer.sv
sv/flow_to_step_rate_generator.sv
verif/frg_status_checker.sv
verif/tb.sv
